### hdl/ius2c_pkg.sv
package ius2c_pkg;

	// Default and reset values of the configuration registers.
	localparam int MAX_WIDTH_DEF = 2048;
	localparam logic [11:0] WIDTH_RST = 12'd640;
	localparam logic [11:0] HEIGHT_RST = 12'd480;

	// Register indexes on the configuration port.
	typedef enum logic {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} reg_idx_t;

	// One BGR pixel, blue in the low byte.
	typedef logic [23:0] pix_t;

	// Source window: row 0 is the oldest row (r-3), column 0 the oldest column (c-3).
	typedef pix_t [3:0][3:0] win_t;

	// Work for the back end: one window and the range of 2x2 blocks it finishes.
	typedef struct packed {
		win_t        win;
		logic [1:0]  dx_lo;
		logic [1:0]  dx_hi;
		logic [1:0]  dy_lo;
		logic [1:0]  dy_hi;
		logic [1:0]  clo;
		logic [1:0]  rlo;
		logic [11:0] ocol_base;
		logic [12:0] orow_base;
	} job_t;

	// One channel of the four-tap filter, rounded half up and clamped.
	function automatic logic [7:0] tap1(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c, input logic [7:0] d);
		logic [12:0] pos;
		logic [12:0] neg;
		logic [12:0] diff;
		logic [8:0]  q;
		pos = 13'(({5'b0, b} + {5'b0, c}) * 13'd9) + 13'd8;
		neg = {5'b0, a} + {5'b0, d};
		diff = pos - neg;
		q = diff[12:4];
		if (pos < neg) begin
			return 8'd0;
		end else if (q > 9'd255) begin
			return 8'd255;
		end else begin
			return q[7:0];
		end
	endfunction

	// The filter applied to all three channels.
	function automatic pix_t tap(input pix_t a, input pix_t b, input pix_t c, input pix_t d);
		pix_t r;
		for (int k = 0; k < 3; k++) begin
			r[k*8 +: 8] = tap1(a[k*8 +: 8], b[k*8 +: 8], c[k*8 +: 8], d[k*8 +: 8]);
		end
		return r;
	endfunction

	// Window index for an offset, held inside [lo, 3] to replicate the edges.
	function automatic logic [1:0] clamp_idx(input logic [2:0] v, input logic [1:0] lo);
		logic [1:0] r;
		r = (v > 3'd3) ? 2'd3 : v[1:0];
		if (r < lo) begin
			r = lo;
		end
		return r;
	endfunction

endpackage

### hdl/ius2c_ram.sv
module ius2c_ram #(
	parameter int WIDTH = 72,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one read port with registered data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### hdl/ius2c_front.sv
module ius2c_front import ius2c_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [23:0]                  s_tdata,
	input  logic                         restart,
	input  logic [$clog2(MAX_WIDTH)-1:0] wlast,
	input  logic [11:0]                  hlast,
	output logic                         job_valid,
	input  logic                         job_ready,
	output job_t                         job
);

	localparam int CW = $clog2(MAX_WIDTH);

	logic [CW-1:0] c_q;
	logic [11:0]   r_q;
	logic          accept;
	logic          v_s1;
	logic [CW-1:0] c_s1;
	logic [11:0]   r_s1;
	pix_t          px_s1;
	logic          byp_s1;
	logic [71:0]   bypd_s1;
	logic [71:0]   rdata;
	logic [71:0]   col_rd;
	logic [71:0]   wdata;
	logic          done;
	logic          has_blocks;
	win_t          win_q;
	win_t          win_n;
	logic          clast;
	logic          rlast;

	assign accept = s_tvalid && s_tready;
	assign s_tready = !v_s1 || done;

	// Source position of the next request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_q <= '0;
			r_q <= '0;
		end else if (restart) begin
			c_q <= '0;
			r_q <= '0;
		end else if (accept) begin
			if (c_q == wlast) begin
				c_q <= '0;
				r_q <= (r_q == hlast) ? 12'd0 : r_q + 12'd1;
			end else begin
				c_q <= c_q + CW'(1);
			end
		end
	end

	// Line buffer: each entry holds rows r-1, r-2, r-3 of one column.
	ius2c_ram #(.WIDTH(72), .DEPTH(MAX_WIDTH)) u_lines (
		.clk   (clk),
		.we    (done),
		.waddr (c_s1),
		.wdata (wdata),
		.re    (accept),
		.raddr (c_q),
		.rdata (rdata)
	);

	// Stage holding the request while its column is read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (done) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			c_s1 <= c_q;
			r_s1 <= r_q;
			px_s1 <= s_tdata;
			byp_s1 <= done && (c_s1 == c_q);
			bypd_s1 <= wdata;
		end
	end

	// A write to the same column in the read cycle is forwarded.
	assign col_rd = byp_s1 ? bypd_s1 : rdata;
	assign wdata = {col_rd[47:0], px_s1};

	// Shift the new column into the window.
	always_comb begin
		for (int row = 0; row < 4; row++) begin
			for (int col = 0; col < 3; col++) begin
				win_n[row][col] = win_q[row][col+1];
			end
		end
		win_n[3][3] = px_s1;
		win_n[2][3] = col_rd[23:0];
		win_n[1][3] = col_rd[47:24];
		win_n[0][3] = col_rd[71:48];
	end

	always_ff @(posedge clk) begin
		if (done) begin
			win_q <= win_n;
		end
	end

	// Range of blocks that this pixel completes.
	assign clast = (c_s1 == wlast);
	assign rlast = (r_s1 == hlast);

	always_comb begin
		job.win = win_n;
		job.dx_lo = (c_s1 >= CW'(2)) ? 2'd0 : 2'd2 - c_s1[1:0];
		job.dx_hi = clast ? 2'd2 : 2'd0;
		job.dy_lo = (r_s1 >= 12'd2) ? 2'd0 : 2'd2 - r_s1[1:0];
		job.dy_hi = rlast ? 2'd2 : 2'd0;
		job.clo = (c_s1 >= CW'(3)) ? 2'd0 : 2'd3 - c_s1[1:0];
		job.rlo = (r_s1 >= 12'd3) ? 2'd0 : 2'd3 - r_s1[1:0];
		job.ocol_base = 12'({c_s1, 1'b0}) - 12'd4;
		job.orow_base = {r_s1, 1'b0} - 13'd4;
	end

	assign has_blocks = (job.dx_lo <= job.dx_hi) && (job.dy_lo <= job.dy_hi);
	assign done = v_s1 && (!has_blocks || job_ready);
	assign job_valid = v_s1 && has_blocks;

endmodule

### hdl/ius2c_queue.sv
module ius2c_queue import ius2c_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  job_t in_job,
	output logic out_valid,
	input  logic out_ready,
	output job_t out_job
);

	job_t       mem_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign in_ready = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;
	assign out_job = mem_q[rptr_q];

	// Two-entry queue between the front and back ends.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= !wptr_q;
			end
			if (pop) begin
				rptr_q <= !rptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= in_job;
		end
	end

endmodule

### hdl/ius2c_back.sv
module ius2c_back import ius2c_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        job_valid,
	output logic        job_pop,
	input  job_t        job,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,  // blue, green, red, out_col(12), out_row(13), zero fill
	output logic        m_tlast   // run_end
);

	logic        started_q;
	logic [1:0]  dx_q;
	logic [1:0]  dy_q;
	logic [1:0]  sub_q;
	logic [1:0]  cur_dx;
	logic [1:0]  cur_dy;
	logic        last;
	logic        en1;
	logic        en2;
	logic        issue;
	logic [1:0]  ri [4];
	logic [1:0]  ci [4];
	pix_t        mid [4];
	pix_t        p01;
	logic        v_s1;
	pix_t        mid_s1 [4];
	pix_t        p00_s1;
	pix_t        p01_s1;
	logic [1:0]  sub_s1;
	logic [11:0] ocol_s1;
	logic [12:0] orow_s1;
	logic        last_s1;
	pix_t        pval;

	assign en2 = !m_tvalid || m_tready;
	assign en1 = !v_s1 || en2;
	assign issue = job_valid && en1;
	assign cur_dx = started_q ? dx_q : job.dx_lo;
	assign cur_dy = started_q ? dy_q : job.dy_lo;
	assign last = (sub_q == 2'd3) && (cur_dx == job.dx_hi) && (cur_dy == job.dy_hi);
	assign job_pop = issue && last;

	// Walk the blocks of a job row by row, four results per block.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			dx_q <= 2'd0;
			dy_q <= 2'd0;
			sub_q <= 2'd0;
		end else if (issue) begin
			sub_q <= sub_q + 2'd1;
			if (last) begin
				started_q <= 1'b0;
			end else begin
				started_q <= 1'b1;
				if (sub_q != 2'd3) begin
					dx_q <= cur_dx;
					dy_q <= cur_dy;
				end else if (cur_dx == job.dx_hi) begin
					dx_q <= job.dx_lo;
					dy_q <= cur_dy + 2'd1;
				end else begin
					dx_q <= cur_dx + 2'd1;
					dy_q <= cur_dy;
				end
			end
		end
	end

	// Row midpoints and column midpoint of the current block.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			ri[i] = clamp_idx({1'b0, cur_dy} + 3'(i), job.rlo);
			ci[i] = clamp_idx({1'b0, cur_dx} + 3'(i), job.clo);
		end
		for (int k = 0; k < 4; k++) begin
			mid[k] = tap(job.win[ri[k]][ci[0]], job.win[ri[k]][ci[1]],
				job.win[ri[k]][ci[2]], job.win[ri[k]][ci[3]]);
		end
		p01 = tap(job.win[ri[0]][ci[1]], job.win[ri[1]][ci[1]],
			job.win[ri[2]][ci[1]], job.win[ri[3]][ci[1]]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			mid_s1 <= mid;
			p00_s1 <= job.win[ri[1]][ci[1]];
			p01_s1 <= p01;
			sub_s1 <= sub_q;
			ocol_s1 <= job.ocol_base + {9'd0, cur_dx, 1'b0} + {11'd0, sub_q[0]};
			orow_s1 <= job.orow_base + {10'd0, cur_dy, 1'b0} + {12'd0, sub_q[1]};
			last_s1 <= last;
		end
	end

	// Pick the result of this position in the block.
	always_comb begin
		case (sub_s1)
			2'd0: pval = p00_s1;
			2'd1: pval = mid_s1[1];
			2'd2: pval = p01_s1;
			default: pval = tap(mid_s1[0], mid_s1[1], mid_s1[2], mid_s1[3]);
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en2) begin
			m_tvalid <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			m_tdata <= {7'd0, orow_s1, ocol_s1, pval};
			m_tlast <= last_s1;
		end
	end

endmodule

### hdl/image_upscale_2x_cubic.sv
// Throughput: one output pixel per cycle from the back end while jobs are queued and m_tready
// is high; the end of a row or frame emits up to 36 outputs in a burst.
// A source pixel is taken each cycle while the two-entry job queue has room.
// Reset clears the position and the handshake state and sets the registers to 640 x 480;
// the line buffer is not cleared and needs no clearing pass.
module image_upscale_2x_cubic import ius2c_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // blue_in, green_in, red_in
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // blue_out, green_out, red_out, out_col, out_row, zero fill
	output logic        m_tlast,   // run_end
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int CW = $clog2(MAX_WIDTH);

	logic [11:0]   width_q;
	logic [11:0]   height_q;
	logic          wr;
	reg_idx_t      idx;
	logic [CW-1:0] wlast;
	logic [11:0]   hlast;
	logic          fq_valid;
	logic          fq_ready;
	job_t          fq_job;
	logic          qb_valid;
	logic          qb_pop;
	job_t          qb_job;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	assign idx = reg_idx_t'(paddr[2]);

	// Configuration registers; any write restarts the frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (wr) begin
			unique case (idx)
				REG_WIDTH: width_q <= pwdata[11:0];
				REG_HEIGHT: height_q <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_WIDTH: prdata = {20'd0, width_q};
			REG_HEIGHT: prdata = {20'd0, height_q};
			default: prdata = '0;
		endcase
	end

	// Last column and row, with zero taken as one and the width held to the buffer.
	always_comb begin
		if (width_q == 12'd0) begin
			wlast = '0;
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			wlast = CW'(MAX_WIDTH - 1);
		end else begin
			wlast = CW'(32'(width_q) - 32'd1);
		end
		hlast = (height_q == 12'd0) ? 12'd0 : height_q - 12'd1;
	end

	ius2c_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.restart   (wr),
		.wlast     (wlast),
		.hlast     (hlast),
		.job_valid (fq_valid),
		.job_ready (fq_ready),
		.job       (fq_job)
	);

	ius2c_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_valid),
		.in_ready  (fq_ready),
		.in_job    (fq_job),
		.out_valid (qb_valid),
		.out_ready (qb_pop),
		.out_job   (qb_job)
	);

	ius2c_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (qb_valid),
		.job_pop   (qb_pop),
		.job       (qb_job),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule
